[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion wrappers, clocked on clk_i; JJC_ASSERT is disabled in the active-low reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check while out of reset.
`define JJC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check at every edge, reset included.
`define JJC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/jjc_pkg.sv]
// ----------------------------------------------------------------------------
// Joystick jog controller package
// Shared types and constants of the jog controller.
// ----------------------------------------------------------------------------
package jjc_pkg;

  // Depth of the queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgSpeedSpan = 2'd0,
    CfgGripMin   = 2'd1,
    CfgGripMax   = 2'd2,
    CfgGripStart = 2'd3
  } cfg_idx_e;

  localparam logic [6:0]  SpanReset    = 7'd20;
  localparam logic [15:0] GripMinReset = 16'd0;
  localparam logic [15:0] GripMaxReset = 16'hFFFF;

  // Classified request carried from front to back
  typedef struct packed {
    logic [31:0]       time_ms;
    logic signed [7:0] spd_x;   // X speed without dead zone (drives Z)
    logic signed [7:0] spd_xd;  // X speed after dead zone
    logic signed [7:0] spd_yd;  // Y speed, inverted, after dead zone
    logic signed [3:0] spd_g;   // gripper speed after dead zone
    logic              axis_btn;
    logic              mode_btn;
  } item_t;

endpackage

[rtl/jjc_if.sv]
// ----------------------------------------------------------------------------
// Joystick jog controller channels
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface jjc_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_ms;
  logic [9:0]  stick_x;
  logic [9:0]  stick_y;
  logic [9:0]  stick_grip;
  logic        axis_button;
  logic        mode_button;

  modport source (output valid, time_ms, stick_x, stick_y, stick_grip, axis_button,
                  mode_button, input ready);
  modport sink (input valid, time_ms, stick_x, stick_y, stick_grip, axis_button,
                mode_button, output ready);
endinterface

interface jjc_rsp_if;
  logic               valid;
  logic               ready;
  logic               axis_mode;
  logic [1:0]         servo_selected;
  logic               z_selected;
  logic signed [15:0] angle_a;
  logic signed [15:0] angle_b;
  logic signed [15:0] angle_c;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] pos_z;
  logic [15:0]        grip_duty;

  modport source (output valid, axis_mode, servo_selected, z_selected, angle_a, angle_b,
                  angle_c, pos_x, pos_y, pos_z, grip_duty, input ready);
  modport sink (input valid, axis_mode, servo_selected, z_selected, angle_a, angle_b,
                angle_c, pos_x, pos_y, pos_z, grip_duty, output ready);
endinterface

interface jjc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/jjc_fifo.sv]
// ----------------------------------------------------------------------------
// Joystick jog controller queue
// Short queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jjc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jjc_pkg::item_t item_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output jjc_pkg::item_t item_o
);

  localparam logic [jjc_pkg::QPtrW-1:0] LastPtr = jjc_pkg::QPtrW'(jjc_pkg::QueueDepth - 1);

  jjc_pkg::item_t                mem_q [jjc_pkg::QueueDepth];
  logic [jjc_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [jjc_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [jjc_pkg::QCntW-1:0]     cnt_q, cnt_d;

  assign ready_o = (cnt_q != jjc_pkg::QCntW'(jjc_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `JJC_ASSERT(a_cnt_bound, cnt_q <= jjc_pkg::QCntW'(jjc_pkg::QueueDepth), "queue overfilled")
  `JJC_ASSERT(a_cnt_push, push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1, "push lost")

endmodule

[rtl/jjc_front.sv]
// ----------------------------------------------------------------------------
// Joystick jog controller front
// Accepts requests, maps stick samples to speeds and applies dead zones.
// ----------------------------------------------------------------------------
module jjc_front (
  input  logic           [6:0] span_i,
  jjc_req_if.sink              req_i,
  input  logic                 q_ready_i,
  output logic                 push_o,
  output jjc_pkg::item_t       item_o
);

  localparam logic [16:0] AdcMax   = 17'd1023;
  localparam logic [5:0]  GripHalf = 6'd7;

  // v * 2half / 1023, truncated, then offset by half
  function automatic logic signed [7:0] map_speed(input logic [9:0] v,
                                                   input logic [5:0] half,
                                                   input logic inv);
    logic [16:0]       prod;
    logic [6:0]        q0;
    logic [16:0]       rem;
    logic [6:0]        q;
    logic signed [7:0] hs;
    logic signed [7:0] qs;
    prod = 17'(v) * 17'({half, 1'b0});
    // p >> 10 is at most one below p / 1023; fix with one compare
    q0   = prod[16:10];
    rem  = prod - {q0, 10'b0} + 17'(q0);
    q    = q0 + 7'(rem >= AdcMax);
    hs   = {2'b00, half};
    qs   = {1'b0, q};
    return inv ? (hs - qs) : (qs - hs);
  endfunction

  function automatic logic signed [7:0] dead_zone(input logic signed [7:0] s);
    return (s >= -8'sd1 && s <= 8'sd1) ? 8'sd0 : s;
  endfunction

  logic [5:0]        half;
  logic signed [7:0] sx;
  logic signed [7:0] sg;

  assign half = span_i[6:1];
  assign sx   = map_speed(req_i.stick_x, half, 1'b0);
  assign sg   = dead_zone(map_speed(req_i.stick_grip, GripHalf, 1'b0));

  assign req_i.ready = q_ready_i;
  assign push_o      = req_i.valid && q_ready_i;

  always_comb begin
    item_o.time_ms  = req_i.time_ms;
    item_o.spd_x    = sx;
    item_o.spd_xd   = dead_zone(sx);
    item_o.spd_yd   = dead_zone(map_speed(req_i.stick_y, half, 1'b1));
    item_o.spd_g    = sg[3:0];
    item_o.axis_btn = req_i.axis_button;
    item_o.mode_btn = req_i.mode_button;
  end

endmodule

[rtl/jjc_back.sv]
// ----------------------------------------------------------------------------
// Joystick jog controller back
// Runs timers, button latches and jog updates; its state is the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jjc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  jjc_pkg::item_t       item_i,
  output logic                 pop_o,
  input  logic          [15:0] grip_min_i,
  input  logic          [15:0] grip_max_i,
  jjc_rsp_if.source            rsp_o
);

  localparam int TAngle = 0;
  localparam int TXy    = 1;
  localparam int TZ     = 2;
  localparam int TGrip  = 3;
  localparam int NumTimers = 4;

  localparam logic [31:0] PeriodAngle = 32'd400;
  localparam logic [31:0] PeriodAxis  = 32'd50;

  function automatic logic signed [23:0] add_sat(input logic signed [23:0] p,
                                                 input logic signed [8:0] d);
    logic signed [24:0] s;
    s = {p[23], p} + {{16{d[8]}}, d};
    if (s[24:23] == 2'b01) begin
      return 24'sh7FFFFF;
    end else if (s[24:23] == 2'b10) begin
      return -24'sh800000;
    end
    return s[23:0];
  endfunction

  logic               out_valid_q;
  logic               mode_q, mode_d;
  logic [1:0]         servo_q, servo_d;
  logic               zsel_q, zsel_d;
  logic               abtn_q, abtn_d;
  logic               xbtn_q, xbtn_d;
  logic               mbtn_q, mbtn_d;
  logic [31:0]        last_q [NumTimers];
  logic [31:0]        last_d [NumTimers];
  logic signed [15:0] angle_q [3];
  logic signed [15:0] angle_d [3];
  logic signed [23:0] pos_q [3];
  logic signed [23:0] pos_d [3];
  logic [15:0]        duty_q, duty_d;

  logic [NumTimers-1:0] fire;
  logic [1:0]           kidx;
  logic signed [7:0]    atmp;
  logic signed [7:0]    ahalf;
  logic signed [7:0]    gx;
  logic signed [7:0]    g15;
  logic signed [17:0]   dsum;
  logic signed [17:0]   gext;
  logic signed [17:0]   mine;
  logic signed [17:0]   maxe;

  // Advance when the result slot is free or being taken
  assign pop_o = valid_i && (!out_valid_q || rsp_o.ready);

  always_comb begin
    for (int k = 0; k < NumTimers; k++) begin
      fire[k] = (item_i.time_ms - last_q[k]) > ((k == TAngle) ? PeriodAngle : PeriodAxis);
    end
  end

  always_comb begin
    mode_d  = mode_q;
    servo_d = servo_q;
    zsel_d  = zsel_q;
    abtn_d  = abtn_q;
    xbtn_d  = xbtn_q;
    mbtn_d  = mbtn_q;
    last_d  = last_q;
    angle_d = angle_q;
    pos_d   = pos_q;
    duty_d  = duty_q;

    kidx  = (servo_q == 2'd3) ? 2'd0 : servo_q;
    // Halve toward zero
    atmp  = item_i.spd_xd + $signed({7'b0, item_i.spd_xd[7]});
    ahalf = atmp >>> 1;

    gx   = {{4{item_i.spd_g[3]}}, item_i.spd_g};
    g15  = (gx <<< 4) - gx;
    gext = {{10{g15[7]}}, g15};
    mine = {2'b00, grip_min_i};
    maxe = {2'b00, grip_max_i};
    dsum = $signed({2'b00, duty_q}) + gext;
    if (dsum > maxe) begin
      dsum = maxe;
    end
    if (dsum < mine) begin
      dsum = mine;
    end

    if (!mode_q) begin
      if (fire[TAngle]) begin
        last_d[TAngle] = item_i.time_ms;
        angle_d[kidx]  = angle_q[kidx] + {{8{ahalf[7]}}, ahalf};
      end
      if (!item_i.axis_btn && !abtn_q) begin
        servo_d = (servo_q == 2'd2) ? 2'd0 : servo_q + 2'd1;
        abtn_d  = 1'b1;
      end else if (item_i.axis_btn) begin
        abtn_d = 1'b0;
      end
    end else begin
      if (!item_i.axis_btn && !xbtn_q) begin
        zsel_d = ~zsel_q;
        xbtn_d = 1'b1;
      end else if (item_i.axis_btn) begin
        xbtn_d = 1'b0;
      end
      // The toggled selection applies in the same pass
      if (!zsel_d) begin
        if (fire[TXy]) begin
          last_d[TXy] = item_i.time_ms;
          pos_d[0]    = add_sat(pos_q[0], {item_i.spd_xd[7], item_i.spd_xd});
          pos_d[1]    = add_sat(pos_q[1], {item_i.spd_yd[7], item_i.spd_yd});
        end
      end else if (fire[TZ]) begin
        last_d[TZ] = item_i.time_ms;
        pos_d[2]   = add_sat(pos_q[2], {item_i.spd_x, 1'b0});
      end
      if (fire[TGrip]) begin
        last_d[TGrip] = item_i.time_ms;
        duty_d        = dsum[15:0];
      end
    end

    if (item_i.mode_btn && !mbtn_q) begin
      mode_d = ~mode_q;
      mbtn_d = 1'b1;
    end else if (!item_i.mode_btn) begin
      mbtn_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mode_q      <= 1'b0;
      servo_q     <= 2'd0;
      zsel_q      <= 1'b0;
      abtn_q      <= 1'b0;
      xbtn_q      <= 1'b0;
      mbtn_q      <= 1'b0;
      duty_q      <= 16'd0;
      for (int k = 0; k < NumTimers; k++) begin
        last_q[k] <= '0;
      end
      for (int k = 0; k < 3; k++) begin
        angle_q[k] <= '0;
        pos_q[k]   <= '0;
      end
    end else begin
      out_valid_q <= pop_o || (out_valid_q && !rsp_o.ready);
      if (pop_o) begin
        mode_q  <= mode_d;
        servo_q <= servo_d;
        zsel_q  <= zsel_d;
        abtn_q  <= abtn_d;
        xbtn_q  <= xbtn_d;
        mbtn_q  <= mbtn_d;
        last_q  <= last_d;
        angle_q <= angle_d;
        pos_q   <= pos_d;
        duty_q  <= duty_d;
      end
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.axis_mode      = mode_q;
  assign rsp_o.servo_selected = servo_q;
  assign rsp_o.z_selected     = zsel_q;
  assign rsp_o.angle_a        = angle_q[0];
  assign rsp_o.angle_b        = angle_q[1];
  assign rsp_o.angle_c        = angle_q[2];
  assign rsp_o.pos_x          = pos_q[0];
  assign rsp_o.pos_y          = pos_q[1];
  assign rsp_o.pos_z          = pos_q[2];
  assign rsp_o.grip_duty      = duty_q;

  `JJC_ASSERT(a_servo_range, servo_q != 2'd3, "servo index out of range")
  `JJC_ASSERT(a_pos_hold_angle, pop_o && !mode_q |=> $stable(pos_q[0]) && $stable(pos_q[1]) && $stable(pos_q[2]) && $stable(duty_q), "axis state moved in angle mode")
  `JJC_ASSERT(a_angle_hold_axis, pop_o && mode_q |=> $stable(angle_q[0]) && $stable(angle_q[1]) && $stable(angle_q[2]), "angle moved in axis mode")

endmodule

[rtl/joystick_jog_controller.sv]
// ----------------------------------------------------------------------------
// Joystick jog controller
// Maps joystick samples to jog speeds and updates servo angles, axis
// positions and gripper duty once per request.
// ----------------------------------------------------------------------------
// Path: an accepted request is written into the queue, and the back registers its result.
// Throughput: one request per cycle while results are taken; the back stage
// registers all state together, and a two-entry queue decouples it from the front.
// Reset: mode, selections, latches, timers, angles, positions and duty clear
// to zero; span, duty limits return to their reset values.
module joystick_jog_controller (
  input logic       clk_i,
  input logic       rst_ni,
  jjc_req_if.sink   req_i,
  jjc_rsp_if.source rsp_o,
  jjc_cfg_if.sink   cfg_i
);

  logic [6:0]     span_q;
  logic [15:0]    grip_min_q;
  logic [15:0]    grip_max_q;

  logic           q_ready;
  logic           push;
  jjc_pkg::item_t push_item;
  logic           q_valid;
  logic           pop;
  jjc_pkg::item_t pop_item;

  assign cfg_i.ready = 1'b1;

  // The start duty only acts at reset, which also clears it; drop its writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q     <= jjc_pkg::SpanReset;
      grip_min_q <= jjc_pkg::GripMinReset;
      grip_max_q <= jjc_pkg::GripMaxReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        jjc_pkg::CfgSpeedSpan: span_q     <= cfg_i.data[6:0];
        jjc_pkg::CfgGripMin:   grip_min_q <= cfg_i.data;
        jjc_pkg::CfgGripMax:   grip_max_q <= cfg_i.data;
        jjc_pkg::CfgGripStart: ;
        default: ;
      endcase
    end
  end

  jjc_front u_front (
    .span_i    (span_q),
    .req_i     (req_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .item_o    (push_item)
  );

  jjc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  jjc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .item_i     (pop_item),
    .pop_o      (pop),
    .grip_min_i (grip_min_q),
    .grip_max_i (grip_max_q),
    .rsp_o      (rsp_o)
  );

endmodule
